// ===== design/lla_pkg.sv =====
// ---------------------------------------------------------------------------
// Life-like cell automaton package
// Shared constants, codes and types of the cell automaton block.
// ---------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 4;

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  localparam logic RK_READ    = 1'b0;
  localparam logic RK_ADVANCE = 1'b1;

  localparam logic [COUNT_W-1:0] KEEP_LO  = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_LO = 4'd4;
  localparam logic [COUNT_W-1:0] BIRTH_HI = 4'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_data;
  } grid_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

`default_nettype wire

// ===== design/lla_if.sv =====
// ---------------------------------------------------------------------------
// Life-like cell automaton channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface lla_item_if;
  logic                        valid;
  logic                        ready;
  logic [lla_pkg::OP_W-1:0]    operation;
  logic [lla_pkg::COORD_W-1:0] cell_row;
  logic [lla_pkg::COORD_W-1:0] cell_col;
  logic                        cell_value;

  modport source (output valid, output operation, output cell_row, output cell_col,
                  output cell_value, input ready);
  modport sink   (input valid, input operation, input cell_row, input cell_col,
                  input cell_value, output ready);
endinterface

interface lla_result_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic read_value;

  modport source (output valid, output result_kind, output read_value, input ready);
  modport sink   (input valid, input result_kind, input read_value, output ready);
endinterface

`default_nettype wire

// ===== design/lla_grid.sv =====
// ---------------------------------------------------------------------------
// Cell grid store
// One-bit cell memory with one write and one registered read port, and a
// clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module lla_grid #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lla_pkg::grid_ctl_t            ctl,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] rd_row,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] wr_row,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  output logic                               rdata,
  output logic                               ready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_HEIGHT * (2 ** CW);

  logic          mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] waddr;
  logic          we;
  logic          wd;

  assign waddr = clearing ? clr_addr : {wr_row, wr_col};
  assign we    = clearing | ctl.wr_en;
  assign wd    = ~clearing & ctl.wr_data;
  assign ready = ~clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wd;
    end
    if (ctl.rd_en) begin
      rdata <= mem[{rd_row, rd_col}];
    end
  end

endmodule

`default_nettype wire

// ===== design/lla_sweep.sv =====
// ---------------------------------------------------------------------------
// Generation sweep
// Raster scan of the grid with a two-row line memory of the old generation
// and a three by three window; writes each new cell back into the grid.
// ---------------------------------------------------------------------------
`default_nettype none

module lla_sweep #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  w_use,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] h_use,
  input  wire logic                            grid_rdata,
  output lla_pkg::grid_ctl_t                   ctl,
  output logic [$clog2(MAX_HEIGHT)-1:0]        rd_row,
  output logic [$clog2(MAX_WIDTH)-1:0]         rd_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]        wr_row,
  output logic [$clog2(MAX_WIDTH)-1:0]         wr_col,
  output lla_pkg::sweep_stat_t                 stat
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int RW1 = $clog2(MAX_HEIGHT + 1);

  logic           active;
  logic [RW1-1:0] row;
  logic [CW1-1:0] col;
  logic           last_col;
  logic           last_row;
  logic           in_grid;

  logic          s1_valid;
  logic          s1_top_row;
  logic          s1_pad;
  logic          s1_fetch;
  logic          s1_first;
  logic          s1_emit;
  logic          s1_last;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_crow;
  logic [CW-1:0] s1_ccol;

  logic          s2_valid;
  logic          s2_emit;
  logic          s2_last;
  logic [RW-1:0] s2_crow;
  logic [CW-1:0] s2_ccol;

  logic [1:0] lb_mem [MAX_WIDTH];
  logic [1:0] lb_q;
  logic [2:0] newcol;
  logic [2:0] win [3];

  logic [lla_pkg::COUNT_W-1:0] count;
  logic                        centre;
  logic                        next_cell;

  assign last_col = (col == w_use);
  assign last_row = (row == h_use);
  assign in_grid  = ~last_col & ~last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && last_col && last_row) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row <= '0;
      col <= '0;
    end else if (active) begin
      if (last_col) begin
        col <= '0;
        row <= row + RW1'(1);
      end else begin
        col <= col + CW1'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && !last_col) begin
      lb_q <= lb_mem[CW'(col)];
    end
    if (s1_valid && !s1_pad) begin
      lb_mem[s1_col] <= newcol[2:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= active;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_top_row <= (row == '0);
    s1_pad     <= last_col;
    s1_fetch   <= in_grid;
    s1_first   <= (col == '0);
    s1_emit    <= (row != '0) && (col != '0);
    s1_last    <= last_col && last_row;
    s1_col     <= CW'(col);
    s1_crow    <= RW'(row - RW1'(1));
    s1_ccol    <= CW'(col - CW1'(1));
    s2_emit    <= s1_emit;
    s2_last    <= s1_last;
    s2_crow    <= s1_crow;
    s2_ccol    <= s1_ccol;
  end

  assign newcol[0] = ~s1_pad & ~s1_top_row & lb_q[0];
  assign newcol[1] = ~s1_pad & ~s1_top_row & lb_q[1];
  assign newcol[2] = s1_fetch & grid_rdata;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1_first) begin
        win[0] <= '0;
        win[1] <= '0;
      end else begin
        win[0] <= win[1];
        win[1] <= win[2];
      end
      win[2] <= newcol;
    end
  end

  always_comb begin
    count = lla_pkg::COUNT_W'(win[0][0]) + lla_pkg::COUNT_W'(win[0][1])
          + lla_pkg::COUNT_W'(win[0][2]) + lla_pkg::COUNT_W'(win[1][0])
          + lla_pkg::COUNT_W'(win[1][2]) + lla_pkg::COUNT_W'(win[2][0])
          + lla_pkg::COUNT_W'(win[2][1]) + lla_pkg::COUNT_W'(win[2][2]);
    centre = win[1][1];
    if (count >= lla_pkg::BIRTH_LO && count <= lla_pkg::BIRTH_HI) begin
      next_cell = 1'b1;
    end else if (count >= lla_pkg::KEEP_LO && count < lla_pkg::BIRTH_LO) begin
      next_cell = centre;
    end else begin
      next_cell = 1'b0;
    end
  end

  assign ctl.rd_en   = active & in_grid;
  assign ctl.wr_en   = s2_valid & s2_emit;
  assign ctl.wr_data = next_cell;
  assign rd_row      = RW'(row);
  assign rd_col      = CW'(col);
  assign wr_row      = s2_crow;
  assign wr_col      = s2_ccol;
  assign stat.busy   = active | s1_valid | s2_valid;
  assign stat.done   = s2_valid & s2_last;

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("sweep started while busy");

  a_no_same_cell : assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en && ctl.wr_en |-> (rd_row != wr_row || rd_col != wr_col))
    else $error("sweep reads and writes the same cell in one cycle");

  a_done_drains : assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !stat.busy)
    else $error("sweep still busy after completion");

endmodule

`default_nettype wire

// ===== design/life_like_cell_automaton.sv =====
// ---------------------------------------------------------------------------
// Life-like cell automaton
// Cell grid with write, read and generation advance commands.
// ---------------------------------------------------------------------------
// A write is stored at acceptance; a read result is registered once the grid has been read and
// the output register is free. An advance scans (h+1)*(w+1) positions, one a cycle, and its
// result is registered once the sweep has drained and the output register is free.
// The next command is accepted once the previous one has finished, even while a result waits.
// After reset the MAX_HEIGHT*2**clog2(MAX_WIDTH) grid cells (4096 by default) are cleared;
// no command is accepted during that time, configuration writes are.
`default_nettype none

module life_like_cell_automaton #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lla_item_if.sink                              item,
  lla_result_if.source                          result,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lla_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int RW1 = $clog2(MAX_HEIGHT + 1);
  localparam int WX  = (CW1 > lla_pkg::CFG_W) ? CW1 : lla_pkg::CFG_W;
  localparam int HX  = (RW1 > lla_pkg::CFG_W) ? RW1 : lla_pkg::CFG_W;

  logic [lla_pkg::CFG_W-1:0] grid_width;
  logic [lla_pkg::CFG_W-1:0] grid_height;
  logic [WX-1:0]             gw_x;
  logic [HX-1:0]             gh_x;
  logic [WX-1:0]             w_use_x;
  logic [HX-1:0]             h_use_x;
  logic [CW1-1:0]            w_use;
  logic [RW1-1:0]            h_use;
  logic                      in_range;

  lla_pkg::state_t state;
  lla_pkg::state_t state_next;

  logic rd_inside;
  logic rd_inside_next;
  logic start;
  logic load;
  logic load_kind;
  logic load_value;
  logic out_free;
  logic out_valid;
  logic out_kind;
  logic out_value;

  lla_pkg::grid_ctl_t   item_ctl;
  lla_pkg::grid_ctl_t   sweep_ctl;
  lla_pkg::grid_ctl_t   grid_ctl;
  lla_pkg::sweep_stat_t sweep_stat;

  logic [RW-1:0] sweep_rd_row;
  logic [CW-1:0] sweep_rd_col;
  logic [RW-1:0] sweep_wr_row;
  logic [CW-1:0] sweep_wr_col;
  logic [RW-1:0] item_row;
  logic [CW-1:0] item_col;
  logic [RW-1:0] grid_rd_row;
  logic [CW-1:0] grid_rd_col;
  logic [RW-1:0] grid_wr_row;
  logic [CW-1:0] grid_wr_col;
  logic          grid_rdata;
  logic          grid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lla_pkg::SIZE_RESET;
      grid_height <= lla_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lla_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        lla_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gw_x = WX'(grid_width);
    gh_x = HX'(grid_height);
    if (gw_x == '0) begin
      w_use_x = WX'(1);
    end else if (gw_x > WX'(MAX_WIDTH)) begin
      w_use_x = WX'(MAX_WIDTH);
    end else begin
      w_use_x = gw_x;
    end
    if (gh_x == '0) begin
      h_use_x = HX'(1);
    end else if (gh_x > HX'(MAX_HEIGHT)) begin
      h_use_x = HX'(MAX_HEIGHT);
    end else begin
      h_use_x = gh_x;
    end
  end

  assign w_use    = CW1'(w_use_x);
  assign h_use    = RW1'(h_use_x);
  assign in_range = (WX'(item.cell_col) < w_use_x) && (HX'(item.cell_row) < h_use_x);
  assign item_row = RW'(item.cell_row);
  assign item_col = CW'(item.cell_col);
  assign out_free = ~out_valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lla_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    item.ready     = 1'b0;
    start          = 1'b0;
    load           = 1'b0;
    load_kind      = lla_pkg::RK_READ;
    load_value     = 1'b0;
    item_ctl       = '0;
    rd_inside_next = rd_inside;
    case (state)
      lla_pkg::ST_CLEAR: begin
        if (grid_ready) begin
          state_next = lla_pkg::ST_IDLE;
        end
      end
      lla_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.operation)
            lla_pkg::OP_WRITE: begin
              item_ctl.wr_en   = in_range;
              item_ctl.wr_data = item.cell_value;
            end
            lla_pkg::OP_READ: begin
              item_ctl.rd_en = in_range;
              rd_inside_next = in_range;
              state_next     = lla_pkg::ST_READ;
            end
            lla_pkg::OP_ADVANCE: begin
              start      = 1'b1;
              state_next = lla_pkg::ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      lla_pkg::ST_READ: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = lla_pkg::RK_READ;
          load_value = rd_inside & grid_rdata;
          state_next = lla_pkg::ST_IDLE;
        end
      end
      lla_pkg::ST_SWEEP: begin
        if (sweep_stat.done) begin
          state_next = lla_pkg::ST_DONE;
        end
      end
      lla_pkg::ST_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = lla_pkg::RK_ADVANCE;
          state_next = lla_pkg::ST_IDLE;
        end
      end
      default: state_next = lla_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_inside <= rd_inside_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= load_kind;
      out_value <= load_value;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_kind;
  assign result.read_value  = out_value;

  always_comb begin
    if (state == lla_pkg::ST_SWEEP) begin
      grid_ctl    = sweep_ctl;
      grid_rd_row = sweep_rd_row;
      grid_rd_col = sweep_rd_col;
      grid_wr_row = sweep_wr_row;
      grid_wr_col = sweep_wr_col;
    end else begin
      grid_ctl    = item_ctl;
      grid_rd_row = item_row;
      grid_rd_col = item_col;
      grid_wr_row = item_row;
      grid_wr_col = item_col;
    end
  end

  lla_grid #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_grid (
    .clk    (clk),
    .rst    (rst),
    .ctl    (grid_ctl),
    .rd_row (grid_rd_row),
    .rd_col (grid_rd_col),
    .wr_row (grid_wr_row),
    .wr_col (grid_wr_col),
    .rdata  (grid_rdata),
    .ready  (grid_ready)
  );

  lla_sweep #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .w_use      (w_use),
    .h_use      (h_use),
    .grid_rdata (grid_rdata),
    .ctl        (sweep_ctl),
    .rd_row     (sweep_rd_row),
    .rd_col     (sweep_rd_col),
    .wr_row     (sweep_wr_row),
    .wr_col     (sweep_wr_col),
    .stat       (sweep_stat)
  );

  a_done_in_sweep : assert property (@(posedge clk) disable iff (rst)
    sweep_stat.done |-> state == lla_pkg::ST_SWEEP)
    else $error("sweep completion outside an advance");

  a_clear_blocks : assert property (@(posedge clk) disable iff (rst)
    !grid_ready |-> state == lla_pkg::ST_CLEAR)
    else $error("grid clearing while commands are served");

  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == lla_pkg::ST_READ || state == lla_pkg::ST_DONE))
    else $error("result raised without a finished read or advance");

  a_advance_starts : assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.operation == lla_pkg::OP_ADVANCE |=> sweep_stat.busy)
    else $error("accepted advance did not start the sweep");

endmodule

`default_nettype wire
